// File: rtl/ssc_pkg.sv
package ssc_pkg;

  localparam int unsigned SERVO_W     = 10;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  HEADER_BYTE     = 8'hFF;
  localparam logic [15:0] RESET_GAP       = 16'd10;
  localparam logic [11:0] MIN_WIDTH_RESET = 12'd1000;
  localparam logic [7:0]  SCALE_RESET     = 8'd39;
  localparam logic [15:0] SLOT_RESET      = 16'd2010;
  localparam logic [15:0] GAP_RESET       = 16'd10000;
  localparam logic [7:0]  TRIM_RESET      = 8'd19;

  // x / 10 == (x * 52429) >> 19 for any 16-bit x
  localparam logic [15:0] RECIP_TENTH = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned K_W         = 24;
  localparam logic [K_W-1:0] K_RESET  = K_W'(int'(SCALE_RESET) * int'(RECIP_TENTH));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WIDTH = 3'd0,
    CFG_SCALE     = 3'd1,
    CFG_SLOT      = 3'd2,
    CFG_GAP       = 3'd3,
    CFG_TRIM      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_BAD  = 2'd2
  } item_kind_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic       rx_error;
  } in_item_t;

  typedef struct packed {
    logic [SERVO_W-1:0] servo_lines;
    logic               gap_started;
    logic               frame_stored;
    logic               byte_rejected;
  } out_item_t;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data;
  } q_entry_t;

  // slot and gap hold effective values (zero already mapped to one)
  typedef struct packed {
    logic [11:0]    min_width;
    logic [K_W-1:0] k;
    logic [15:0]    slot;
    logic [15:0]    gap;
    logic [7:0]     trim;
  } cfg_t;

endpackage

// File: rtl/ssc_front.sv
module ssc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ssc_pkg::in_item_t in_item_i,
  output logic              in_stall_o,
  output logic              q_valid_o,
  output ssc_pkg::q_entry_t q_entry_o,
  input  logic              q_pop_i
);
  import ssc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t   entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic       push, pop;
  q_entry_t   entry;

  always_comb begin
    entry.data = in_item_i.rx_byte;
    if (!in_item_i.mode) begin
      entry.kind = KIND_TICK;
    end else if (in_item_i.rx_error) begin
      entry.kind = KIND_BAD;
    end else begin
      entry.kind = KIND_BYTE;
    end
  end

  assign in_stall_o = (count_q == CNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = entries_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_valid_o && q_pop_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    count_d = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= entry;
    end
  end

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(push) && !$past(pop) |-> q_valid_o)
    else $error("queued item not visible to back end");

endmodule

// File: rtl/ssc_back.sv
module ssc_back #(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssc_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  ssc_pkg::q_entry_t  q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  output ssc_pkg::out_item_t out_item_o,
  input  logic               out_stall_i
);
  import ssc_pkg::*;

  localparam int unsigned CW = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [1:0] {
    P_HDR  = 2'd0,
    P_CHAN = 2'd1,
    P_POS  = 2'd2
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [IW-1:0]           chosen_q, chosen_d;
  logic [7:0]              tab_q   [NUM_CHANNELS];
  logic [7:0]              tab_d   [NUM_CHANNELS];
  logic [7:0]              latch_q [NUM_CHANNELS];
  logic [7:0]              latch_d [NUM_CHANNELS];
  logic [CW-1:0]           chan_q, chan_d;
  logic [15:0]             slot_q, slot_d;
  logic [15:0]             pulse_q, pulse_d;
  logic [NUM_CHANNELS-1:0] lines_q, lines_d;
  out_item_t               out_q, out_d;
  logic                    out_valid_q;

  logic        chan_live;
  logic [7:0]  cur_pos;
  logic [31:0] prod;
  logic [13:0] width;
  logic [15:0] pticks;

  // pulse length for the channel about to be raised
  assign chan_live = (chan_q < CW'(NUM_CHANNELS));
  assign cur_pos   = chan_live ? latch_q[chan_q[IW-1:0]] : '0;
  assign prod      = 32'(cur_pos) * 32'(cfg_i.k);
  assign width     = 14'(cfg_i.min_width) + 14'(prod[31:RECIP_SHIFT]);
  assign pticks    = (width <= 14'(cfg_i.trim)) ? 16'd1 : 16'(width - 14'(cfg_i.trim));

  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    logic [15:0] slot_dec;
    phase_d  = phase_q;
    chosen_d = chosen_q;
    tab_d    = tab_q;
    latch_d  = latch_q;
    chan_d   = chan_q;
    slot_d   = slot_q;
    pulse_d  = pulse_q;
    lines_d  = lines_q;
    out_d    = '0;
    slot_dec = (slot_q != '0) ? slot_q - 16'd1 : '0;
    if (q_pop_o) begin
      unique case (q_entry_i.kind)
        KIND_TICK: begin
          if (pulse_q != '0) begin
            pulse_d = pulse_q - 16'd1;
            if (pulse_q == 16'd1) lines_d = '0;
          end
          slot_d = slot_dec;
          if (slot_dec == '0) begin
            if (chan_live) begin
              lines_d = lines_d | (NUM_CHANNELS'(1) << chan_q);
              pulse_d = pticks;
              slot_d  = cfg_i.slot;
              chan_d  = chan_q + CW'(1);
            end else begin
              out_d.gap_started = 1'b1;
              latch_d = tab_q;
              slot_d  = cfg_i.gap;
              chan_d  = '0;
            end
          end
        end
        KIND_BAD: out_d.byte_rejected = 1'b1;
        KIND_BYTE: begin
          unique case (phase_q)
            P_CHAN: begin
              if (q_entry_i.data < 8'(NUM_CHANNELS)) begin
                chosen_d = q_entry_i.data[IW-1:0];
                phase_d  = P_POS;
              end else begin
                phase_d = P_HDR;
                out_d.byte_rejected = 1'b1;
              end
            end
            P_POS: begin
              tab_d[chosen_q]    = q_entry_i.data;
              out_d.frame_stored = 1'b1;
              phase_d            = P_HDR;
            end
            default: phase_d = (q_entry_i.data == HEADER_BYTE) ? P_CHAN : P_HDR;
          endcase
        end
        default: ;
      endcase
      out_d.servo_lines = SERVO_W'(lines_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_HDR;
      chosen_q    <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        tab_q[i]   <= '0;
        latch_q[i] <= '0;
      end
      chan_q      <= CW'(NUM_CHANNELS);
      slot_q      <= RESET_GAP;
      pulse_q     <= '0;
      lines_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q  <= phase_d;
      chosen_q <= chosen_d;
      tab_q    <= tab_d;
      latch_q  <= latch_d;
      chan_q   <= chan_d;
      slot_q   <= slot_d;
      pulse_q  <= pulse_d;
      lines_q  <= lines_d;
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_q <= CW'(NUM_CHANNELS))
    else $error("channel index past sequence end");

  a_lines_need_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_q != '0 |-> pulse_q != '0)
    else $error("servo line high with no pulse running");

  a_gap_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.gap_started |-> chan_q == '0)
    else $error("gap result without sequence restart");

endmodule

// File: rtl/serial_servo_pulse_controller.sv
// Serial servo pulse controller.
// Input channel (in_valid_i / in_stall_o, in_item_i): each item is a 1 us
// tick (mode 0) or a received serial byte (mode 1). Frames 0xFF, channel,
// position set a channel's 8-bit position; bytes flagged rx_error are dropped.
// Output channel (out_valid_o / out_stall_i, out_item_o): exactly one result
// per item, in order: line levels after the item plus status flags.
// Configuration (cfg_valid_i / cfg_ready_o): index 0 min width, 1 scale in
// tenths, 2 slot length, 3 gap length, 4 trim; other indexes are ignored.
// Write only while no item is in flight.
// An accepted item is written into the queue; the back end pops it and
// registers its result. Throughput: one item per clock while the receiver
// does not stall, set by the sequencer/parser update in the back end.
// A two-entry queue sits between front and back end; when the receiver
// stalls, the result register holds, the queue fills and in_stall_o rises.
// Reset: registers take their default values, positions clear, all lines
// low, and the first gap opens after 10 ticks.
module serial_servo_pulse_controller #(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  ssc_pkg::in_item_t                   in_item_i,
  output logic                                in_stall_o,
  output logic                                out_valid_o,
  output ssc_pkg::out_item_t                  out_item_o,
  input  logic                                out_stall_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ssc_pkg::*;

  logic [11:0]    min_width_q;
  logic [K_W-1:0] k_q;
  logic [15:0]    slot_q;
  logic [15:0]    gap_q;
  logic [7:0]     trim_q;
  cfg_t           cfg;
  logic           q_valid;
  logic           q_pop;
  q_entry_t       q_entry;

  assign cfg_ready_o = 1'b1;

  // scale is kept premultiplied by the reciprocal of ten
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q <= MIN_WIDTH_RESET;
      k_q         <= K_RESET;
      slot_q      <= SLOT_RESET;
      gap_q       <= GAP_RESET;
      trim_q      <= TRIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_WIDTH: min_width_q <= cfg_data_i[11:0];
        CFG_SCALE:     k_q <= K_W'(cfg_data_i[7:0]) * K_W'(RECIP_TENTH);
        CFG_SLOT:      slot_q <= (cfg_data_i == '0) ? 16'd1 : cfg_data_i;
        CFG_GAP:       gap_q  <= (cfg_data_i == '0) ? 16'd1 : cfg_data_i;
        CFG_TRIM:      trim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.min_width = min_width_q;
    cfg.k         = k_q;
    cfg.slot      = slot_q;
    cfg.gap       = gap_q;
    cfg.trim      = trim_q;
  end

  ssc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  ssc_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ssc_pkg::*;

  localparam int unsigned N_CH        = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic        MODE_TICK   = 1'b0;
  localparam logic        MODE_BYTE   = 1'b1;
  localparam int unsigned LAST_REG    = CFG_TRIM;
  localparam int unsigned TOP_IDX     = (1 << CFG_IDX_W) - 1;

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_CHAN = 2'd1,
    PH_POS  = 2'd2
  } parse_phase_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  in_item_t              in_item_i   = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_item_t             out_item_o;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // servo model state
  logic [11:0]  min_w_cfg;
  logic [7:0]   scale_cfg;
  logic [15:0]  slot_cfg;
  logic [15:0]  gap_cfg;
  logic [7:0]   trim_cfg;
  parse_phase_e parse_ph;
  logic [3:0]   sel_chan;
  logic [7:0]   pos_table [N_CH];
  logic [7:0]   latched   [N_CH];
  int unsigned  next_chan;
  logic [15:0]  slot_left;
  logic [15:0]  pulse_left;
  logic [N_CH-1:0] lines;

  out_item_t    expected_q [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  stall_burst    = 0;
  bit           idling         = 1'b0;

  serial_servo_pulse_controller #(
    .NUM_CHANNELS(N_CH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_stall_i <= 1'b1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      stall_burst <= $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    if (mismatch_count < 40)
      $display("%0t: %s got %0h expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_item_o), 0);
      end else begin
        want = expected_q.pop_front();
        if (out_item_o.servo_lines !== want.servo_lines)
          report_mismatch("servo_lines", 32'(out_item_o.servo_lines),
                          32'(want.servo_lines));
        if (out_item_o.gap_started !== want.gap_started)
          report_mismatch("gap_started", 32'(out_item_o.gap_started),
                          32'(want.gap_started));
        if (out_item_o.frame_stored !== want.frame_stored)
          report_mismatch("frame_stored", 32'(out_item_o.frame_stored),
                          32'(want.frame_stored));
        if (out_item_o.byte_rejected !== want.byte_rejected)
          report_mismatch("byte_rejected", 32'(out_item_o.byte_rejected),
                          32'(want.byte_rejected));
      end
    end
  end

  function automatic void servo_model_reset();
    min_w_cfg  = MIN_WIDTH_RESET;
    scale_cfg  = SCALE_RESET;
    slot_cfg   = SLOT_RESET;
    gap_cfg    = GAP_RESET;
    trim_cfg   = TRIM_RESET;
    parse_ph   = PH_HDR;
    sel_chan   = '0;
    for (int i = 0; i < N_CH; i++) begin
      pos_table[i] = '0;
      latched[i]   = '0;
    end
    next_chan  = N_CH;
    slot_left  = RESET_GAP;
    pulse_left = '0;
    lines      = '0;
  endfunction

  function automatic logic [15:0] pulse_len(logic [7:0] pos);
    int unsigned w;
    w = int'(min_w_cfg) + (int'(pos) * int'(scale_cfg)) / 10;
    if (w <= int'(trim_cfg))
      return 16'd1;
    return 16'(w - int'(trim_cfg));
  endfunction

  function automatic out_item_t servo_step(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.mode == MODE_BYTE) begin
      if (it.rx_error) begin
        r.byte_rejected = 1'b1;
      end else begin
        case (parse_ph)
          PH_CHAN: begin
            if (it.rx_byte < N_CH) begin
              sel_chan = it.rx_byte[3:0];
              parse_ph = PH_POS;
            end else begin
              parse_ph = PH_HDR;
              r.byte_rejected = 1'b1;
            end
          end
          PH_POS: begin
            pos_table[sel_chan] = it.rx_byte;
            r.frame_stored = 1'b1;
            parse_ph = PH_HDR;
          end
          default: parse_ph = (it.rx_byte == HEADER_BYTE) ? PH_CHAN : PH_HDR;
        endcase
      end
    end else begin
      // running pulse first, then the slot countdown
      if (pulse_left != 0) begin
        pulse_left = pulse_left - 1'b1;
        if (pulse_left == 0)
          lines = '0;
      end
      if (slot_left != 0)
        slot_left = slot_left - 1'b1;
      if (slot_left == 0) begin
        if (next_chan < N_CH) begin
          lines[next_chan] = 1'b1;
          pulse_left = pulse_len(latched[next_chan]);
          slot_left  = (slot_cfg == 0) ? 16'd1 : slot_cfg;
          next_chan++;
        end else begin
          r.gap_started = 1'b1;
          latched   = pos_table;
          slot_left = (gap_cfg == 0) ? 16'd1 : gap_cfg;
          next_chan = 0;
        end
      end
    end
    r.servo_lines = lines;
    return r;
  endfunction

  function automatic in_item_t make_item(logic mode, logic [7:0] data, logic err);
    in_item_t it;
    it.mode     = mode;
    it.rx_byte  = data;
    it.rx_error = err;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(servo_step(it));
  endtask

  task automatic send_byte(logic [7:0] data, logic err);
    send_item(make_item(MODE_BYTE, data, err));
  endtask

  // byte field and error flag carry junk on ticks
  task automatic send_tick();
    send_item(make_item(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_WIDTH: min_w_cfg = val[11:0];
      CFG_SCALE:     scale_cfg = val[7:0];
      CFG_SLOT:      slot_cfg  = val;
      CFG_GAP:       gap_cfg   = val;
      CFG_TRIM:      trim_cfg  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [11:0] mw, logic [7:0] sc, logic [15:0] sl,
                            logic [15:0] gp, logic [7:0] tr);
    wait_idle();
    write_reg(CFG_MIN_WIDTH, 16'(mw));
    write_reg(CFG_SCALE, 16'(sc));
    write_reg(CFG_SLOT, sl);
    write_reg(CFG_GAP, gp);
    write_reg(CFG_TRIM, 16'(tr));
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_IDX_W'($urandom_range(LAST_REG + 1, TOP_IDX)),
                16'($urandom_range(0, 65535)));
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed frames and ticks, some broken frames and line noise
  task automatic run_traffic(int unsigned n);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_tick();
        sent++;
      end else if (pick < 84) begin
        send_byte(HEADER_BYTE, 1'b0);
        send_byte(8'($urandom_range(0, N_CH - 1)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        sent += 3;
      end else if (pick < 88) begin
        send_byte(HEADER_BYTE, 1'b0);
        send_byte(8'($urandom_range(N_CH, 255)), 1'b0);
        sent += 2;
      end else if (pick < 92) begin
        // error byte in mid-frame leaves the parser where it was
        send_byte(HEADER_BYTE, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(8'($urandom_range(0, N_CH - 1)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        sent += 4;
      end else if (pick < 96) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  task automatic test_frame_parsing();
    idling = 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(HEADER_BYTE, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(HEADER_BYTE, 1'b0);
    send_byte(8'(N_CH - 1), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(HEADER_BYTE, 1'b0);
    send_byte(8'(N_CH), 1'b0);
    send_byte(HEADER_BYTE, 1'b0);
    send_byte(HEADER_BYTE, 1'b0);
    send_byte(HEADER_BYTE, 1'b1);
    send_byte(HEADER_BYTE, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'd3, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  // ten ticks out of reset open the gap; shrink timing before the tenth so it stays short
  task automatic test_reset_gap();
    repeat (9) send_tick();
    set_timing(12'd1, 8'd0, 16'd1, 16'd1, 8'd0);
    repeat (3) send_tick();
  endtask

  task automatic test_timing_extremes();
    idling = 1'b1;
    set_timing(12'd4095, 8'd255, 16'd0, 16'd0, 8'd0);
    run_traffic(60);
    set_timing(12'd0, 8'd0, 16'd1, 16'd1, 8'd0);
    run_traffic(60);
    set_timing(12'd0, 8'd255, 16'd1, 16'd0, 8'd255);
    run_traffic(60);
  endtask

  task automatic test_random_traffic();
    logic [7:0] sc;
    for (int ph = 0; ph < 8; ph++) begin
      idling = ($urandom_range(0, 3) != 0);
      sc = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 4));
      set_timing(12'($urandom_range(0, 12)), sc, 16'($urandom_range(0, 8)),
                 16'($urandom_range(0, 10)), 8'($urandom_range(0, 16)));
      run_traffic(120);
    end
  endtask

  task automatic test_steady_stream();
    idling = 1'b0;
    set_timing(12'($urandom_range(0, 8)), 8'($urandom_range(0, 4)),
               16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
               8'($urandom_range(0, 8)));
    run_traffic(150);
    // longest slot and gap get loaded at the next sequencer event
    set_timing(12'd4095, 8'd0, 16'd65535, 16'd65535, 8'd255);
    run_traffic(40);
  endtask

  initial begin
    servo_model_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_frame_parsing();
    test_reset_gap();
    test_timing_extremes();
    test_random_traffic();
    test_steady_stream();
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: serial_servo_pulse_controller.f
rtl/ssc_pkg.sv
rtl/ssc_front.sv
rtl/ssc_back.sv
rtl/serial_servo_pulse_controller.sv
sim/tb_top.sv
